### hw/rtl/spc_pkg.sv
// ----------------------------------------------------------------------------
// spc_pkg
// Shared widths, register indexes and exponent constants for the soil
// percolation datapath.
// ----------------------------------------------------------------------------
package spc_pkg;

   localparam int MOIST_W   = 16;
   localparam int INFLOW_W  = 20;
   localparam int OUTFLOW_W = 25;
   localparam int THK_W     = 14;
   localparam int KSAT_W    = 20;
   localparam int PSI_W     = 12;
   localparam int STEP_W    = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THICKNESS = 3'd0,
      CSR_POROSITY  = 3'd1,
      CSR_RESIDUAL  = 3'd2,
      CSR_KSAT      = 3'd3,
      CSR_PSI       = 3'd4,
      CSR_STEP      = 3'd5
   } csr_index_type;

   // floor square root, one result bit per round
   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] t;
      r = '0;
      for (int i = 31; i >= 0; i--) begin
         t = r | (64'd1 << i);
         if (t * t <= v) begin
            r = t;
         end
      end
      return r;
   endfunction

   // Q30 value of 2^-(2^-k), built by repeated square roots from 2^29
   function automatic logic [30:0] exp2_coef(input int k);
      logic [63:0] c;
      c = 64'd1 << 29;
      for (int j = 1; j <= k; j++) begin
         c = isqrt64(c << 30);
      end
      return c[30:0];
   endfunction

endpackage

### hw/rtl/spc_div.sv
// ----------------------------------------------------------------------------
// spc_div
// Pipelined restoring divider: one quotient bit per stage, side word carried.
// ----------------------------------------------------------------------------
module spc_div #(
   parameter int NUM_W = 32,
   parameter int DEN_W = 16,
   parameter int TAG_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output logic [NUM_W-1:0] out_quo,
   output logic [TAG_W-1:0] out_tag
);

   logic             vld_ff [NUM_W];
   logic [NUM_W-1:0] nq_ff  [NUM_W];
   logic [DEN_W-1:0] rem_ff [NUM_W];
   logic [DEN_W-1:0] den_ff [NUM_W];
   logic [TAG_W-1:0] tag_ff [NUM_W];

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic             vld_src;
      logic [NUM_W-1:0] nq_src;
      logic [DEN_W-1:0] rem_src;
      logic [DEN_W-1:0] den_src;
      logic [TAG_W-1:0] tag_src;
      logic [DEN_W:0]   trial;
      logic [DEN_W:0]   diff;
      logic             ge;
      logic [NUM_W-1:0] nq_in;
      logic [DEN_W-1:0] rem_in;

      if (k == 0) begin : g_first
         assign vld_src = in_valid;
         assign nq_src  = in_num;
         assign rem_src = '0;
         assign den_src = in_den;
         assign tag_src = in_tag;
      end else begin : g_next
         assign vld_src = vld_ff[k-1];
         assign nq_src  = nq_ff[k-1];
         assign rem_src = rem_ff[k-1];
         assign den_src = den_ff[k-1];
         assign tag_src = tag_ff[k-1];
      end

      // shift in the next dividend bit and try a subtract
      assign trial  = {rem_src, nq_src[NUM_W-1]};
      assign diff   = trial - {1'b0, den_src};
      assign ge     = trial >= {1'b0, den_src};
      assign nq_in  = {nq_src[NUM_W-2:0], ge};
      assign rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_src;
         end
         nq_ff[k]  <= nq_in;
         rem_ff[k] <= rem_in;
         den_ff[k] <= den_src;
         tag_ff[k] <= tag_src;
      end
   end

   assign out_valid = vld_ff[NUM_W-1];
   assign out_quo   = nq_ff[NUM_W-1];
   assign out_tag   = tag_ff[NUM_W-1];

endmodule

### hw/rtl/spc_nlog2.sv
// ----------------------------------------------------------------------------
// spc_nlog2
// Pipelined -log2(x / 2^FB) in Q16: leading one, normalise, 16 squarings.
// ----------------------------------------------------------------------------
module spc_nlog2 #(
   parameter int X_W   = 17,
   parameter int FB    = 16,
   parameter int TAG_W = 1,
   parameter int NW    = $clog2(X_W),
   parameter int IW    = $clog2(FB + 1),
   parameter int LW    = IW + 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [X_W-1:0]   in_x,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output logic [LW-1:0]    out_log,
   output logic [TAG_W-1:0] out_tag
);

   localparam int SQ_N = 16;

   // leading one
   logic [X_W-1:0]   xz;
   logic [NW-1:0]    lead;
   logic             va_ff;
   logic [X_W-1:0]   xa_ff;
   logic [NW-1:0]    na_ff;
   logic [TAG_W-1:0] ta_ff;

   always_comb begin
      xz = (in_x == '0) ? X_W'(1) : in_x;
      lead = '0;
      for (int i = 0; i < X_W; i++) begin
         if (xz[i]) begin
            lead = NW'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else begin
         va_ff <= in_valid;
      end
      xa_ff <= xz;
      na_ff <= lead;
      ta_ff <= in_tag;
   end

   // normalise to a Q30 mantissa
   logic [4:0]       sh;
   logic [30:0]      mb_in;
   logic             vb_ff;
   logic [30:0]      mb_ff;
   logic [NW-1:0]    nb_ff;
   logic [TAG_W-1:0] tb_ff;

   assign sh    = 5'd30 - 5'(na_ff);
   assign mb_in = 31'(xa_ff) << sh;

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else begin
         vb_ff <= va_ff;
      end
      mb_ff <= mb_in;
      nb_ff <= na_ff;
      tb_ff <= ta_ff;
   end

   // squarings, one fraction bit each
   logic             vs_ff [SQ_N];
   logic [30:0]      ms_ff [SQ_N];
   logic [15:0]      fr_ff [SQ_N];
   logic [NW-1:0]    ns_ff [SQ_N];
   logic [TAG_W-1:0] ts_ff [SQ_N];

   for (genvar j = 0; j < SQ_N; j++) begin : g_sq
      logic             v_src;
      logic [30:0]      m_src;
      logic [15:0]      f_src;
      logic [NW-1:0]    n_src;
      logic [TAG_W-1:0] t_src;
      logic [61:0]      sq;
      logic [31:0]      top;
      logic [30:0]      m_in;
      logic [15:0]      f_in;

      if (j == 0) begin : g_first
         assign v_src = vb_ff;
         assign m_src = mb_ff;
         assign f_src = '0;
         assign n_src = nb_ff;
         assign t_src = tb_ff;
      end else begin : g_next
         assign v_src = vs_ff[j-1];
         assign m_src = ms_ff[j-1];
         assign f_src = fr_ff[j-1];
         assign n_src = ns_ff[j-1];
         assign t_src = ts_ff[j-1];
      end

      assign sq   = 62'(m_src) * 62'(m_src);
      assign top  = sq[61:30];
      assign m_in = top[31] ? top[31:1] : top[30:0];
      assign f_in = {f_src[14:0], top[31]};

      always_ff @(posedge clock) begin
         if (reset) begin
            vs_ff[j] <= 1'b0;
         end else begin
            vs_ff[j] <= v_src;
         end
         ms_ff[j] <= m_in;
         fr_ff[j] <= f_in;
         ns_ff[j] <= n_src;
         ts_ff[j] <= t_src;
      end
   end

   // integer part minus fraction
   logic [IW-1:0]    ipart;
   logic             big;
   logic [LW-1:0]    res_in;
   logic             vo_ff;
   logic [LW-1:0]    res_ff;
   logic [TAG_W-1:0] to_ff;

   assign ipart  = IW'(FB) - IW'(ns_ff[SQ_N-1]);
   assign big    = 32'(ns_ff[SQ_N-1]) > 32'(FB);
   assign res_in = big ? '0 : ({ipart, 16'd0} - LW'(fr_ff[SQ_N-1]));

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else begin
         vo_ff <= vs_ff[SQ_N-1];
      end
      res_ff <= res_in;
      to_ff  <= ts_ff[SQ_N-1];
   end

   assign out_valid = vo_ff;
   assign out_log   = res_ff;
   assign out_tag   = to_ff;

endmodule

### hw/rtl/spc_exp2n.sv
// ----------------------------------------------------------------------------
// spc_exp2n
// Pipelined 2^-e, e in Q16, result Q30: one fraction bit per stage, then shift.
// ----------------------------------------------------------------------------
module spc_exp2n #(
   parameter int E_W   = 26,
   parameter int TAG_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [E_W-1:0]   in_e,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output logic [30:0]      out_val,
   output logic [TAG_W-1:0] out_tag
);
   import spc_pkg::*;

   localparam int FR_N = 16;

   logic             v_ff [FR_N];
   logic [30:0]      m_ff [FR_N];
   logic [E_W-1:0]   e_ff [FR_N];
   logic [TAG_W-1:0] t_ff [FR_N];

   for (genvar k = 0; k < FR_N; k++) begin : g_frac
      localparam logic [30:0] COEF = exp2_coef(k + 1);
      logic             v_src;
      logic [30:0]      m_src;
      logic [E_W-1:0]   e_src;
      logic [TAG_W-1:0] t_src;
      logic [61:0]      prod;
      logic [30:0]      m_in;

      if (k == 0) begin : g_first
         assign v_src = in_valid;
         assign m_src = 31'h4000_0000;
         assign e_src = in_e;
         assign t_src = in_tag;
      end else begin : g_next
         assign v_src = v_ff[k-1];
         assign m_src = m_ff[k-1];
         assign e_src = e_ff[k-1];
         assign t_src = t_ff[k-1];
      end

      assign prod = 62'(m_src) * 62'(COEF);
      assign m_in = e_src[15-k] ? prod[60:30] : m_src;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else begin
            v_ff[k] <= v_src;
         end
         m_ff[k] <= m_in;
         e_ff[k] <= e_src;
         t_ff[k] <= t_src;
      end
   end

   // integer part: shift right, flush when 31 or more
   logic [E_W-17:0]  ip;
   logic [30:0]      res_in;
   logic             vo_ff;
   logic [30:0]      res_ff;
   logic [TAG_W-1:0] to_ff;

   assign ip     = e_ff[FR_N-1][E_W-1:16];
   assign res_in = (ip >= (E_W-16)'(31)) ? '0 : (m_ff[FR_N-1] >> ip[4:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else begin
         vo_ff <= v_ff[FR_N-1];
      end
      res_ff <= res_in;
      to_ff  <= t_ff[FR_N-1];
   end

   assign out_valid = vo_ff;
   assign out_val   = res_ff;
   assign out_tag   = to_ff;

endmodule

### hw/rtl/soil_percolation_step.sv
// ----------------------------------------------------------------------------
// soil_percolation_step
// Brooks-Corey percolation out of one soil layer per cell, fully pipelined.
// ----------------------------------------------------------------------------
//
//  channel   ports                                  word moved
//  -------   -------------------------------------  -------------------------
//  request   start, busy, req_*                     moisture, inflow
//  response  rsp_strobe, rsp_outflow_um             outflow
//  csr       csr_valid, csr_ready, csr_index/data   one register write
//
// One word enters per clock; busy stays low, so a request is taken whenever
// start is high. Each result comes out in request order, after passing through
// the chain of bit-serial divider stages, log squarings and exp stages.
// The receiver cannot stall, so the pipeline advances on every clock.
// Reset (synchronous) clears the valid bits and loads the register defaults.
// CSR writes are always ready and must only be made while the pipe is empty.
//
module soil_percolation_step (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [spc_pkg::MOIST_W-1:0]       req_moisture_frac,
   input  logic [spc_pkg::INFLOW_W-1:0]      req_inflow_um,
   output logic                              rsp_strobe,
   output logic [spc_pkg::OUTFLOW_W-1:0]     rsp_outflow_um,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [spc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [spc_pkg::CSR_DATA_W-1:0]    csr_data
);
   import spc_pkg::*;

   // ---------------------------------------------------------------- csr
   logic [THK_W-1:0]  thk_ff;
   logic [15:0]       por_ff;
   logic [15:0]       res_ff;
   logic [KSAT_W-1:0] ksat_ff;
   logic [PSI_W-1:0]  psi_ff;
   logic [STEP_W-1:0] step_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         thk_ff  <= THK_W'(1000);
         por_ff  <= 16'd29491;
         res_ff  <= 16'd3277;
         ksat_ff <= KSAT_W'(10000);
         psi_ff  <= PSI_W'(256);
         step_ff <= STEP_W'(1);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_THICKNESS: thk_ff  <= csr_data[THK_W-1:0];
            CSR_POROSITY:  por_ff  <= csr_data[15:0];
            CSR_RESIDUAL:  res_ff  <= csr_data[15:0];
            CSR_KSAT:      ksat_ff <= csr_data[KSAT_W-1:0];
            CSR_PSI:       psi_ff  <= csr_data[PSI_W-1:0];
            CSR_STEP:      step_ff <= csr_data[STEP_W-1:0];
            default: begin
               // drop writes beyond the register list
            end
         endcase
      end
   end

   // Derived soil constants; they settle in the clock after a write, well before
   // any word reaches the stages that use them.
   logic [23:0] thk_um_ff;
   logic [13:0] eq8_ff;
   logic [15:0] dpr_ff;
   logic        bad_ff;
   logic [THK_W-1:0] thk_eff;

   assign thk_eff = (thk_ff == '0) ? THK_W'(1) : thk_ff;

   always_ff @(posedge clock) begin
      thk_um_ff <= 24'(thk_eff) * 24'd1000;
      eq8_ff    <= {2'b0, psi_ff} + {2'b0, psi_ff} + 14'd768;
      dpr_ff    <= por_ff - res_ff;
      bad_ff    <= (por_ff <= res_ff) || (ksat_ff == '0);
   end

   // ---------------------------------------------------------- p0: capture
   logic        v0_ff;
   logic [15:0] th0_ff;
   logic [19:0] inf0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= start && !busy;
      end
      th0_ff  <= req_moisture_frac;
      inf0_ff <= req_inflow_um;
   end

   // ------------------------------------- moisture gained: inflow / thickness
   // side word layout: {moisture, inflow}
   logic        va;
   logic [35:0] qa;
   logic [35:0] ta;

   spc_div #(.NUM_W(36), .DEN_W(24), .TAG_W(36)) u_div_gain (
      .clock(clock), .reset(reset),
      .in_valid(v0_ff), .in_num({inf0_ff, 16'd0}), .in_den(thk_um_ff),
      .in_tag({th0_ff, inf0_ff}),
      .out_valid(va), .out_quo(qa), .out_tag(ta)
   );

   // ------------------------------------ p1: raised moisture, bounds, s dividend
   logic [27:0] theta1;
   logic [3:0]  fl1_in;
   logic        v1_ff;
   logic [35:0] base1_ff;
   logic [3:0]  fl1_ff;
   logic [31:0] ns0_ff;
   logic [31:0] ns1_ff;

   assign theta1 = {12'd0, ta[35:20]} + {1'b0, qa[26:0]};
   // flags: {at or below residual, at or above porosity} for start, then raised moisture
   assign fl1_in = {ta[35:20] <= res_ff, ta[35:20] >= por_ff,
                    theta1 <= {12'd0, res_ff}, theta1 >= {12'd0, por_ff}};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= va;
      end
      base1_ff <= ta;
      fl1_ff   <= fl1_in;
      ns0_ff   <= {ta[35:20] - res_ff, 16'd0};
      ns1_ff   <= {theta1[15:0] - res_ff, 16'd0};
   end

   // ------------------------------------------------ relative saturation s
   logic        vs0;
   logic [31:0] qs0;
   logic [31:0] qs1;
   logic [37:0] ts0;
   logic [1:0]  ts1;

   spc_div #(.NUM_W(32), .DEN_W(16), .TAG_W(38)) u_div_s0 (
      .clock(clock), .reset(reset),
      .in_valid(v1_ff), .in_num(ns0_ff), .in_den(dpr_ff),
      .in_tag({base1_ff, fl1_ff[3:2]}),
      .out_valid(vs0), .out_quo(qs0), .out_tag(ts0)
   );

   spc_div #(.NUM_W(32), .DEN_W(16), .TAG_W(2)) u_div_s1 (
      .clock(clock), .reset(reset),
      .in_valid(v1_ff), .in_num(ns1_ff), .in_den(dpr_ff),
      .in_tag(fl1_ff[1:0]),
      .out_valid(), .out_quo(qs1), .out_tag(ts1)
   );

   // ------------------------------------------------------------- -log2(s)
   logic        vl0;
   logic [20:0] lg0;
   logic [20:0] lg1;
   logic [37:0] tl0;
   logic [1:0]  tl1;

   spc_nlog2 #(.X_W(17), .FB(16), .TAG_W(38)) u_log_s0 (
      .clock(clock), .reset(reset),
      .in_valid(vs0), .in_x(qs0[16:0]), .in_tag(ts0),
      .out_valid(vl0), .out_log(lg0), .out_tag(tl0)
   );

   spc_nlog2 #(.X_W(17), .FB(16), .TAG_W(2)) u_log_s1 (
      .clock(clock), .reset(reset),
      .in_valid(vs0), .in_x(qs1[16:0]), .in_tag(ts1),
      .out_valid(), .out_log(lg1), .out_tag(tl1)
   );

   // ------------------------------------------- p2: scale by exponent 2b+3
   logic [33:0] pe0;
   logic [33:0] pe1;
   logic        v2_ff;
   logic [25:0] ex0_ff;
   logic [25:0] ex1_ff;
   logic [37:0] t2a_ff;
   logic [1:0]  t2b_ff;

   assign pe0 = 34'(lg0) * 34'(eq8_ff);
   assign pe1 = 34'(lg1) * 34'(eq8_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= vl0;
      end
      ex0_ff <= pe0[33:8];
      ex1_ff <= pe1[33:8];
      t2a_ff <= tl0;
      t2b_ff <= tl1;
   end

   // ----------------------------------------------------- s^(2b+3) in Q30
   logic        ve0;
   logic [30:0] xp0;
   logic [30:0] xp1;
   logic [37:0] te0;
   logic [1:0]  te1;

   spc_exp2n #(.E_W(26), .TAG_W(38)) u_exp_k0 (
      .clock(clock), .reset(reset),
      .in_valid(v2_ff), .in_e(ex0_ff), .in_tag(t2a_ff),
      .out_valid(ve0), .out_val(xp0), .out_tag(te0)
   );

   spc_exp2n #(.E_W(26), .TAG_W(2)) u_exp_k1 (
      .clock(clock), .reset(reset),
      .in_valid(v2_ff), .in_e(ex1_ff), .in_tag(t2b_ff),
      .out_valid(), .out_val(xp1), .out_tag(te1)
   );

   // -------------------------------------------- p3: conductivity products
   logic        v3_ff;
   logic [36:0] pk0_ff;
   logic [36:0] pk1_ff;
   logic [35:0] base3_ff;
   logic [3:0]  fl3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= ve0;
      end
      pk0_ff   <= 37'(ksat_ff) * 37'(xp0[30:14]);
      pk1_ff   <= 37'(ksat_ff) * 37'(xp1[30:14]);
      base3_ff <= te0[37:2];
      fl3_ff   <= {te0[1:0], te1};
   end

   // ------------------------------------- p4: bound cases, average of two
   logic [36:0] kfull;
   logic [36:0] k0;
   logic [36:0] k1;
   logic [37:0] ksum;
   logic        v4_ff;
   logic [36:0] kavg4_ff;
   logic [35:0] base4_ff;

   assign kfull = {1'b0, ksat_ff, 16'd0};
   assign k0    = fl3_ff[3] ? '0 : (fl3_ff[2] ? kfull : pk0_ff);
   assign k1    = fl3_ff[1] ? '0 : (fl3_ff[0] ? kfull : pk1_ff);
   assign ksum  = {1'b0, k0} + {1'b0, k1};

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      kavg4_ff <= ksum[37:1];
      base4_ff <= base3_ff;
   end

   // ------------------------------------------ relative conductivity Kavg/Ksat
   // side word layout: {moisture, inflow, kavg}
   logic        vq;
   logic [50:0] qq;
   logic [72:0] tq;

   spc_div #(.NUM_W(51), .DEN_W(20), .TAG_W(73)) u_div_q (
      .clock(clock), .reset(reset),
      .in_valid(v4_ff), .in_num({kavg4_ff, 14'd0}), .in_den(ksat_ff),
      .in_tag({base4_ff, kavg4_ff}),
      .out_valid(vq), .out_quo(qq), .out_tag(tq)
   );

   // ------------------------------------------------ p5: zero test, clamp
   logic        v5_ff;
   logic [30:0] q5_ff;
   logic [73:0] t5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= vq;
      end
      q5_ff <= (qq > 51'h4000_0000) ? 31'h4000_0000 : qq[30:0];
      t5_ff <= {tq, qq == '0};
   end

   // -------------------------------- invert the power law: 2^(log2(q)/e)
   logic        vlq;
   logic [20:0] lgq;
   logic [73:0] tlq;
   logic        vde;
   logic [28:0] qde;
   logic [73:0] tde;
   logic        vea;
   logic [30:0] sa;
   logic [73:0] tea;

   spc_nlog2 #(.X_W(31), .FB(30), .TAG_W(74)) u_log_q (
      .clock(clock), .reset(reset),
      .in_valid(v5_ff), .in_x(q5_ff), .in_tag(t5_ff),
      .out_valid(vlq), .out_log(lgq), .out_tag(tlq)
   );

   spc_div #(.NUM_W(29), .DEN_W(14), .TAG_W(74)) u_div_e (
      .clock(clock), .reset(reset),
      .in_valid(vlq), .in_num({lgq, 8'd0}), .in_den(eq8_ff), .in_tag(tlq),
      .out_valid(vde), .out_quo(qde), .out_tag(tde)
   );

   spc_exp2n #(.E_W(29), .TAG_W(74)) u_exp_s (
      .clock(clock), .reset(reset),
      .in_valid(vde), .in_e(qde), .in_tag(tde),
      .out_valid(vea), .out_val(sa), .out_tag(tea)
   );

   // --------------------------------------- p6: scale saturation to moisture
   logic [30:0] sa_m;
   logic        v6_ff;
   logic [46:0] prod6_ff;
   logic [35:0] base6_ff;
   logic [36:0] kavg6_ff;

   assign sa_m = tea[0] ? '0 : sa;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else begin
         v6_ff <= vea;
      end
      prod6_ff <= 47'(sa_m) * 47'(dpr_ff);
      base6_ff <= tea[73:38];
      kavg6_ff <= tea[37:1];
   end

   // ------------------------------ p7: moisture surplus, flow at Kavg
   logic [31:0] tavg;
   logic [32:0] diff7_in;
   logic [41:0] flow_full;
   logic        v7_ff;
   logic signed [32:0] diff7_ff;
   logic [25:0] flow7_ff;
   logic [19:0] inf7_ff;

   assign tavg      = 32'(prod6_ff[46:16]) + 32'({res_ff, 14'd0});
   assign diff7_in  = 33'({base6_ff[35:20], 14'd0}) - 33'(tavg);
   assign flow_full = 42'(kavg6_ff) * 42'(step_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else begin
         v7_ff <= v6_ff;
      end
      diff7_ff <= $signed(diff7_in);
      flow7_ff <= flow_full[41:16];
      inf7_ff  <= base6_ff[19:0];
   end

   // ------------------------------------------ p8: surplus times thickness
   logic        v8_ff;
   logic signed [57:0] prod8_ff;
   logic [25:0] flow8_ff;
   logic [19:0] inf8_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff <= 1'b0;
      end else begin
         v8_ff <= v7_ff;
      end
      prod8_ff <= diff7_ff * $signed({1'b0, thk_um_ff});
      flow8_ff <= flow7_ff;
      inf8_ff  <= inf7_ff;
   end

   // ---------------------------------------------- p9: water available
   logic        v9_ff;
   logic signed [57:0] avail9_ff;
   logic [25:0] flow9_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v9_ff <= 1'b0;
      end else begin
         v9_ff <= v8_ff;
      end
      avail9_ff <= $signed({8'd0, inf8_ff, 30'd0}) + prod8_ff;
      flow9_ff  <= flow8_ff;
   end

   // ---------------------------------------------- p10: limit and present
   logic [27:0] avail_um;
   logic [27:0] flow_lim;
   logic        rsp_strobe_ff;
   logic [OUTFLOW_W-1:0] rsp_outflow_ff;

   assign avail_um = avail9_ff[57:30];

   always_comb begin
      if (bad_ff || avail9_ff[57]) begin
         flow_lim = '0;
      end else if (avail_um < {2'd0, flow9_ff}) begin
         flow_lim = avail_um;
      end else begin
         flow_lim = {2'd0, flow9_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= v9_ff;
      end
      rsp_outflow_ff <= flow_lim[OUTFLOW_W-1:0];
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_outflow_um = rsp_outflow_ff;

endmodule
